// File: sv/nps_pkg.sv
package nps_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;

   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 2;
   localparam int POINT_BITS = 3 * COORD_BITS;
   localparam int AXES       = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } nps_op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } nps_status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } nps_state_type;

   // controller to datapath
   typedef struct packed {
      logic           load;
      logic           clear;
      logic           start;
      logic           issue;
      logic           post_imm;
      logic           post_scan;
      nps_status_type code;
   } nps_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic last;
      logic drained;
   } nps_sts_type;

endpackage

// File: sv/nps_ram.sv
module nps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/nps_datapath.sv
module nps_datapath import nps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  nps_cmd_type           cmd,
   output nps_sts_type           sts,
   input  logic [COORD_BITS-1:0] req_coord_x,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic [COORD_BITS-1:0] req_coord_z,
   output logic [IDX_BITS-1:0]   rsp_nearest_index,
   output logic [DIST_BITS-1:0]  rsp_min_distance_sq,
   output logic [CNT_BITS-1:0]   rsp_point_count,
   output logic [COORD_BITS-1:0] rsp_extent_x_low,
   output logic [COORD_BITS-1:0] rsp_extent_x_high,
   output logic [COORD_BITS-1:0] rsp_extent_y_low,
   output logic [COORD_BITS-1:0] rsp_extent_y_high,
   output logic [COORD_BITS-1:0] rsp_extent_z_low,
   output logic [COORD_BITS-1:0] rsp_extent_z_high,
   output logic [1:0]            rsp_status
);

   coord_type in_c [AXES];

   logic [CNT_BITS-1:0] count_ff, count_in;
   coord_type           low_ff  [AXES];
   coord_type           low_in  [AXES];
   coord_type           high_ff [AXES];
   coord_type           high_in [AXES];

   coord_type           query_ff [AXES];
   logic [IDX_BITS-1:0] rd_addr_ff;
   logic                v1_ff, v2_ff, first_ff;
   logic [IDX_BITS-1:0] idx1_ff, idx2_ff;
   logic [SQ_BITS-1:0]  sq_ff [AXES];
   logic [SQ_BITS-1:0]  sq_in [AXES];
   logic [DIST_BITS-1:0] best_ff, sum;
   logic [IDX_BITS-1:0] best_idx_ff;

   logic [POINT_BITS-1:0] mem_rd;
   coord_type             mem_c [AXES];
   logic signed [COORD_BITS:0]     diff [AXES];
   logic signed [SQ_BITS-1:0]      prod [AXES];

   logic [IDX_BITS-1:0]   out_idx_ff;
   logic [DIST_BITS-1:0]  out_dist_ff;
   logic [CNT_BITS-1:0]   out_count_ff;
   coord_type             out_low_ff  [AXES];
   coord_type             out_high_ff [AXES];
   nps_status_type        out_status_ff;

   logic store_en;

   assign in_c[0] = req_coord_x;
   assign in_c[1] = req_coord_y;
   assign in_c[2] = req_coord_z;

   assign sts.empty   = (count_ff == '0);
   assign sts.full    = (count_ff == CNT_BITS'(MAX_POINTS));
   assign sts.last    = (CNT_BITS'(rd_addr_ff) == count_ff - CNT_BITS'(1));
   assign sts.drained = !v1_ff && !v2_ff;

   assign store_en = cmd.load && !sts.full;

   nps_ram #(
      .WIDTH (POINT_BITS),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data ({req_coord_x, req_coord_y, req_coord_z}),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rd)
   );

   // count and extents; the first point sets both ends of each axis
   always_comb begin
      count_in = count_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (cmd.clear) begin
         count_in = '0;
         for (int k = 0; k < AXES; k++) begin
            low_in[k]  = '0;
            high_in[k] = '0;
         end
      end else if (store_en) begin
         count_in = count_ff + CNT_BITS'(1);
         for (int k = 0; k < AXES; k++) begin
            if (sts.empty || in_c[k] < low_ff[k]) begin
               low_in[k] = in_c[k];
            end
            if (sts.empty || in_c[k] > high_ff[k]) begin
               high_in[k] = in_c[k];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         mem_c[k] = mem_rd[(AXES-k)*COORD_BITS-1 -: COORD_BITS];
         diff[k]  = {query_ff[k][COORD_BITS-1], query_ff[k]}
                  - {mem_c[k][COORD_BITS-1], mem_c[k]};
         prod[k]  = SQ_BITS'(diff[k]) * SQ_BITS'(diff[k]);
         sq_in[k] = prod[k];
      end
   end

   assign sum = DIST_BITS'(sq_ff[0]) + DIST_BITS'(sq_ff[1]) + DIST_BITS'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         first_ff <= 1'b0;
         for (int k = 0; k < AXES; k++) begin
            low_ff[k]  <= '0;
            high_ff[k] <= '0;
         end
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         v1_ff    <= cmd.issue;
         v2_ff    <= v1_ff;
         if (cmd.start) begin
            first_ff <= 1'b1;
         end else if (v2_ff) begin
            first_ff <= 1'b0;
         end
      end
   end

   // scan pipeline: read, square, accumulate and compare
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_addr_ff <= '0;
         query_ff   <= in_c;
      end else if (cmd.issue) begin
         rd_addr_ff <= rd_addr_ff + IDX_BITS'(1);
      end
      idx1_ff <= rd_addr_ff;
      if (v1_ff) begin
         sq_ff   <= sq_in;
         idx2_ff <= idx1_ff;
      end
      // strict compare keeps the lowest index on a tie
      if (v2_ff && (first_ff || sum < best_ff)) begin
         best_ff     <= sum;
         best_idx_ff <= idx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post_imm || cmd.post_scan) begin
         out_count_ff  <= count_in;
         out_low_ff    <= low_in;
         out_high_ff   <= high_in;
         out_status_ff <= cmd.code;
         if (cmd.post_scan) begin
            out_idx_ff  <= best_idx_ff;
            out_dist_ff <= best_ff;
         end else begin
            out_idx_ff  <= (store_en) ? count_ff[IDX_BITS-1:0] : '0;
            out_dist_ff <= '0;
         end
      end
   end

   assign rsp_nearest_index   = out_idx_ff;
   assign rsp_min_distance_sq = out_dist_ff;
   assign rsp_point_count     = out_count_ff;
   assign rsp_extent_x_low    = out_low_ff[0];
   assign rsp_extent_x_high   = out_high_ff[0];
   assign rsp_extent_y_low    = out_low_ff[1];
   assign rsp_extent_y_high   = out_high_ff[1];
   assign rsp_extent_z_low    = out_low_ff[2];
   assign rsp_extent_z_high   = out_high_ff[2];
   assign rsp_status          = out_status_ff;

endmodule

// File: sv/nps_ctrl.sv
module nps_ctrl import nps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output nps_cmd_type cmd,
   input  nps_sts_type sts
);

   nps_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free, take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign take      = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      cmd.code = STATUS_OK;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req_command)
                  OP_LOAD: begin
                     cmd.load     = 1'b1;
                     cmd.post_imm = 1'b1;
                     if (sts.full) begin
                        cmd.code = STATUS_FULL;
                     end
                  end
                  OP_QUERY: begin
                     if (sts.empty) begin
                        cmd.post_imm = 1'b1;
                        cmd.code     = STATUS_EMPTY;
                     end else begin
                        cmd.start = 1'b1;
                        state_in  = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear    = 1'b1;
                     cmd.post_imm = 1'b1;
                  end
                  default: begin
                     cmd.post_imm = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the pipeline to empty and the output to be free
            if (sts.drained && out_free) begin
               cmd.post_scan = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.post_imm || cmd.post_scan) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.post_imm || cmd.post_scan) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result posted over a pending transaction");

   a_post_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.post_imm || cmd.post_scan) |=> rsp_valid_ff)
      else $error("posted result not presented");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !sts.empty)
      else $error("scan started on an empty store");

   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && sts.last) |=> !cmd.issue)
      else $error("read issued beyond the last stored point");

endmodule

// File: sv/nearest_point_search_with_extents_top.sv
// Nearest stored point search over up to MAX_POINTS signed Q8.8 points,
// with running x/y/z extents. A load, a clear or any other command gives its
// result in the cycle after acceptance; a query walks the stored points
// through the single read port of the point memory, one point a cycle,
// through a read, square and compare pipeline. One transaction is worked on
// at a time; a finished result sits in the output register until it is taken,
// and the next transaction is accepted only once the output is free or being
// taken. Each transaction yields exactly one result. The point memory needs
// no clearing after reset.
module nearest_point_search_with_extents_top import nps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [COORD_BITS-1:0] req_coord_x,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic [COORD_BITS-1:0] req_coord_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_BITS-1:0]   rsp_nearest_index,
   output logic [DIST_BITS-1:0]  rsp_min_distance_sq,
   output logic [CNT_BITS-1:0]   rsp_point_count,
   output logic [COORD_BITS-1:0] rsp_extent_x_low,
   output logic [COORD_BITS-1:0] rsp_extent_x_high,
   output logic [COORD_BITS-1:0] rsp_extent_y_low,
   output logic [COORD_BITS-1:0] rsp_extent_y_high,
   output logic [COORD_BITS-1:0] rsp_extent_z_low,
   output logic [COORD_BITS-1:0] rsp_extent_z_high,
   output logic [1:0]            rsp_status
);

   nps_cmd_type cmd;
   nps_sts_type sts;

   nps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   nps_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_coord_x         (req_coord_x),
      .req_coord_y         (req_coord_y),
      .req_coord_z         (req_coord_z),
      .rsp_nearest_index   (rsp_nearest_index),
      .rsp_min_distance_sq (rsp_min_distance_sq),
      .rsp_point_count     (rsp_point_count),
      .rsp_extent_x_low    (rsp_extent_x_low),
      .rsp_extent_x_high   (rsp_extent_x_high),
      .rsp_extent_y_low    (rsp_extent_y_low),
      .rsp_extent_y_high   (rsp_extent_y_high),
      .rsp_extent_z_low    (rsp_extent_z_low),
      .rsp_extent_z_high   (rsp_extent_z_high),
      .rsp_status          (rsp_status)
   );

endmodule
